>>> rtl/nal_pkg.sv
package nal_pkg;

   localparam logic [63:0] PI_Q61  = 64'h6487ED5110B4611A;
   localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
   localparam logic [63:0] WORK_LIMIT = 64'h2000_0000_0000_0000;

   localparam logic [2:0] ALU_MULRAW = 3'd0;
   localparam logic [2:0] ALU_MUL30  = 3'd1;
   localparam logic [2:0] ALU_MUL60  = 3'd2;
   localparam logic [2:0] ALU_SQRT   = 3'd3;
   localparam logic [2:0] ALU_DIV    = 3'd4;

   typedef struct packed {
      logic [7:0]         degree;
      logic [7:0]         order;
      logic signed [31:0] argument;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               bad_args;
   } rsp_word_type;

   typedef struct packed {
      logic        start;
      logic [2:0]  op;
      logic [63:0] a;
      logic [63:0] b;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;

   function automatic logic [63:0] calc_inv_four_pi();
      logic [64:0] r;
      logic [63:0] q;
      r = 65'd1;
      q = 64'd0;
      for (int i = 0; i < 117; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= {1'b0, PI_Q61}) begin
            r = r - {1'b0, PI_Q61};
            q[0] = 1'b1;
         end
      end
      if (r >= ({1'b0, PI_Q61} - r)) begin
         q = q + 64'd1;
      end
      return q;
   endfunction

   localparam logic [63:0] INV_FOUR_PI_Q58 = calc_inv_four_pi();

endpackage

>>> rtl/nal_alu.sv
module nal_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  nal_pkg::alu_req_type alu_req,
   output nal_pkg::alu_rsp_type alu_rsp
);

   logic         busy_ff, busy_in;
   logic [2:0]   op_ff, op_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  pp_ff, pp_in;
   logic [33:0]  rem_ff, rem_in;
   logic [31:0]  root_ff, root_in;
   logic [63:0]  drem_ff, drem_in;
   logic         done_ff, done_in;
   logic [63:0]  result_ff, result_in;

   logic [1:0]   k;
   logic [31:0]  ah, bh;
   logic [127:0] pp_wide;
   logic [127:0] rnd;
   logic [127:0] shifted;
   logic [35:0]  sq_rem;
   logic [35:0]  sq_trial;
   logic [64:0]  dv_rem;
   logic         qbit;

   always_comb begin
      busy_in   = busy_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      pp_in     = pp_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      drem_in   = drem_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      k         = cnt_ff[2:1];
      ah        = k[0] ? a_ff[63:32] : a_ff[31:0];
      bh        = k[1] ? b_ff[63:32] : b_ff[31:0];
      pp_wide   = {64'd0, pp_ff};
      rnd       = acc_ff + ((op_ff == nal_pkg::ALU_MUL30) ? (128'd1 << 29) : (128'd1 << 59));
      shifted   = (op_ff == nal_pkg::ALU_MUL30) ? (rnd >> 30) : (rnd >> 60);
      sq_rem    = {rem_ff, a_ff[63:62]};
      sq_trial  = {2'b00, root_ff, 2'b01};
      dv_rem    = {drem_ff, a_ff[63]};
      qbit      = (dv_rem >= {1'b0, b_ff});

      if (!busy_ff) begin
         if (alu_req.start) begin
            busy_in = 1'b1;
            op_in   = alu_req.op;
            a_in    = alu_req.a;
            b_in    = alu_req.b;
            cnt_in  = 7'd0;
            acc_in  = 128'd0;
            rem_in  = 34'd0;
            root_in = 32'd0;
            drem_in = 64'd0;
         end
      end else begin
         case (op_ff)
            nal_pkg::ALU_MULRAW, nal_pkg::ALU_MUL30, nal_pkg::ALU_MUL60: begin
               if (cnt_ff < 7'd8) begin
                  cnt_in = cnt_ff + 7'd1;
                  if (!cnt_ff[0]) begin
                     pp_in = ah * bh;
                  end else begin
                     case (k)
                        2'd0:    acc_in = acc_ff + pp_wide;
                        2'd3:    acc_in = acc_ff + (pp_wide << 64);
                        default: acc_in = acc_ff + (pp_wide << 32);
                     endcase
                  end
               end else begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  if (op_ff == nal_pkg::ALU_MULRAW) begin
                     result_in = acc_ff[63:0];
                  end else if (shifted > {64'd0, nal_pkg::WORK_LIMIT}) begin
                     result_in = nal_pkg::WORK_LIMIT;
                  end else begin
                     result_in = shifted[63:0];
                  end
               end
            end
            nal_pkg::ALU_SQRT: begin
               if (cnt_ff < 7'd32) begin
                  cnt_in = cnt_ff + 7'd1;
                  a_in   = {a_ff[61:0], 2'b00};
                  if (sq_rem >= sq_trial) begin
                     rem_in  = 34'(sq_rem - sq_trial);
                     root_in = {root_ff[30:0], 1'b1};
                  end else begin
                     rem_in  = sq_rem[33:0];
                     root_in = {root_ff[30:0], 1'b0};
                  end
               end else begin
                  busy_in   = 1'b0;
                  done_in   = 1'b1;
                  result_in = {32'd0, root_ff};
               end
            end
            nal_pkg::ALU_DIV: begin
               if (cnt_ff < 7'd64) begin
                  cnt_in = cnt_ff + 7'd1;
                  a_in   = {a_ff[62:0], qbit};
                  if (qbit) begin
                     drem_in = 64'(dv_rem - {1'b0, b_ff});
                  end else begin
                     drem_in = dv_rem[63:0];
                  end
               end else begin
                  busy_in   = 1'b0;
                  done_in   = 1'b1;
                  result_in = a_ff;
               end
            end
            default: begin
               busy_in = 1'b0;
               done_in = 1'b1;
               result_in = 64'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
         op_ff   <= nal_pkg::ALU_MULRAW;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      pp_ff     <= pp_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      drem_ff   <= drem_in;
      result_ff <= result_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = result_ff;

endmodule

>>> rtl/normalized_assoc_legendre_top.sv
// Normalised associated Legendre function P_l^m(x) with spherical-harmonic scaling, from
// degree, order and a Q1.30 argument, returned as a saturated Q7.24 value; order above
// degree or an argument outside [-1,1] returns zero with bad_args set. One word is worked
// at a time: req_ready is low from acceptance until the result is loaded into the output
// register, which may still be waiting while the next word is taken. All multiplies,
// divides and square roots run on one shared unit (four-pass 32x32 multiply,
// one-bit-a-cycle divide, two-bits-a-cycle square root).
module normalized_assoc_legendre_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nal_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output nal_pkg::rsp_word_type rsp_word
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_XSQ  = 5'd1;
   localparam logic [4:0] S_PM1  = 5'd2;
   localparam logic [4:0] S_PDIV = 5'd3;
   localparam logic [4:0] S_PM2  = 5'd4;
   localparam logic [4:0] S_SQ1  = 5'd5;
   localparam logic [4:0] S_CM   = 5'd6;
   localparam logic [4:0] S_SQ2  = 5'd7;
   localparam logic [4:0] S_RT   = 5'd8;
   localparam logic [4:0] S_RS1  = 5'd9;
   localparam logic [4:0] S_RS2  = 5'd10;
   localparam logic [4:0] S_RD1  = 5'd11;
   localparam logic [4:0] S_RD2  = 5'd12;
   localparam logic [4:0] S_P1A  = 5'd13;
   localparam logic [4:0] S_P1B  = 5'd14;
   localparam logic [4:0] S_RA   = 5'd15;
   localparam logic [4:0] S_RB   = 5'd16;
   localparam logic [4:0] S_RC   = 5'd17;
   localparam logic [4:0] S_FIN  = 5'd18;

   logic [4:0]         state_ff, state_in;
   logic               issue_ff, issue_in;
   logic               bad_ff, bad_in;
   logic               first_ff, first_in;
   logic [7:0]         l_ff, l_in;
   logic [7:0]         m_ff, m_in;
   logic signed [31:0] x_ff, x_in;
   logic [30:0]        xm_ff, xm_in;
   logic [63:0]        omx2_ff, omx2_in;
   logic [63:0]        prod_ff, prod_in;
   logic [8:0]         i_ff, i_in;
   logic signed [63:0] t_ff, t_in;
   logic [63:0]        sa_ff, sa_in;
   logic [63:0]        sb_ff, sb_in;
   logic [31:0]        sn_ff, sn_in;
   logic [31:0]        sd_ff, sd_in;
   logic [63:0]        f_ff, f_in;
   logic [63:0]        inv_ff, inv_in;
   logic [63:0]        invp_ff, invp_in;
   logic signed [63:0] p0_ff, p0_in;
   logic signed [63:0] p1_ff, p1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   nal_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   nal_pkg::alu_req_type alu_req;
   nal_pkg::alu_rsp_type alu_rsp;

   logic [32:0]        arg_mag;
   logic signed [63:0] x64;
   logic signed [63:0] sx, sy;
   logic               neg;
   logic [63:0]        r;
   logic signed [63:0] sres;
   logic [15:0]        ll_sq, m_sq;
   logic [19:0]        num, den;
   logic [63:0]        p0v;
   logic [8:0]         ll_next;
   logic [63:0]        vmag;
   logic [47:0]        rmag;

   nal_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign arg_mag   = req_word.argument[31] ? 33'(-{req_word.argument[31], req_word.argument})
                                            : {1'b0, req_word.argument};
   assign x64       = {{32{x_ff[31]}}, x_ff};
   assign r         = alu_rsp.result;
   assign ll_sq     = i_ff[7:0] * i_ff[7:0];
   assign m_sq      = m_ff * m_ff;
   assign num       = first_ff ? {11'd0, m_ff, 1'b1} + 20'd2 : {2'd0, ll_sq, 2'b00} - 20'd1;
   assign den       = first_ff ? 20'd1 : {4'd0, ll_sq - m_sq};
   assign p0v       = (r + 64'd262144) >> 19;

   // signed operand pairs
   always_comb begin
      case (state_ff)
         S_P1A:   begin sx = x64;  sy = p0_ff; end
         S_P1B:   begin sx = t_ff; sy = $signed(f_ff); end
         S_RA:    begin sx = x64;  sy = p1_ff; end
         S_RB:    begin sx = p0_ff; sy = $signed(invp_ff); end
         default: begin sx = t_ff; sy = $signed(f_ff); end
      endcase
      neg  = sx[63] ^ sy[63];
      sres = neg ? -$signed(r) : $signed(r);
   end

   always_comb begin
      alu_req.start = issue_ff;
      alu_req.op    = nal_pkg::ALU_MUL30;
      alu_req.a     = sx[63] ? 64'(-sx) : 64'(sx);
      alu_req.b     = sy[63] ? 64'(-sy) : 64'(sy);
      case (state_ff)
         S_XSQ: begin
            alu_req.op = nal_pkg::ALU_MULRAW;
            alu_req.a  = {33'd0, xm_ff};
            alu_req.b  = {33'd0, xm_ff};
         end
         S_PM1: begin
            alu_req.op = nal_pkg::ALU_MUL60;
            alu_req.a  = prod_ff;
            alu_req.b  = omx2_ff;
         end
         S_PDIV: begin
            alu_req.op = nal_pkg::ALU_DIV;
            alu_req.a  = nal_pkg::ONE_Q60;
            alu_req.b  = {54'd0, i_ff, 1'b0};
         end
         S_PM2: begin
            alu_req.op = nal_pkg::ALU_MUL60;
            alu_req.a  = prod_ff;
            alu_req.b  = nal_pkg::ONE_Q60 - t_ff;
         end
         S_SQ1: begin
            alu_req.op = nal_pkg::ALU_SQRT;
            alu_req.a  = prod_ff;
         end
         S_CM: begin
            alu_req.op = nal_pkg::ALU_MULRAW;
            alu_req.a  = {55'd0, m_ff, 1'b1};
            alu_req.b  = nal_pkg::INV_FOUR_PI_Q58;
         end
         S_SQ2: begin
            alu_req.op = nal_pkg::ALU_SQRT;
            alu_req.a  = t_ff;
         end
         S_RT: begin
            alu_req.op = nal_pkg::ALU_MULRAW;
            alu_req.a  = sa_ff;
            alu_req.b  = sb_ff;
         end
         S_RS1: begin
            alu_req.op = nal_pkg::ALU_SQRT;
            alu_req.a  = {num, 44'd0};
         end
         S_RS2: begin
            alu_req.op = nal_pkg::ALU_SQRT;
            alu_req.a  = {den, 44'd0};
         end
         S_RD1: begin
            alu_req.op = nal_pkg::ALU_DIV;
            alu_req.a  = {2'd0, sn_ff, 30'd0};
            alu_req.b  = {32'd0, sd_ff};
         end
         S_RD2: begin
            alu_req.op = nal_pkg::ALU_DIV;
            alu_req.a  = {2'd0, sd_ff, 30'd0};
            alu_req.b  = {32'd0, sn_ff};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      issue_in     = 1'b0;
      bad_in       = bad_ff;
      first_in     = first_ff;
      l_in         = l_ff;
      m_in         = m_ff;
      x_in         = x_ff;
      xm_in        = xm_ff;
      omx2_in      = omx2_ff;
      prod_in      = prod_ff;
      i_in         = i_ff;
      t_in         = t_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      sn_in        = sn_ff;
      sd_in        = sd_ff;
      f_in         = f_ff;
      inv_in       = inv_ff;
      invp_in      = invp_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      ll_next      = i_ff + 9'd1;
      vmag         = p1_ff[63] ? 64'(-p1_ff) : 64'(p1_ff);
      rmag         = 48'((vmag + 64'd32768) >> 16);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               l_in  = req_word.degree;
               m_in  = req_word.order;
               x_in  = req_word.argument;
               xm_in = arg_mag[30:0];
               if ((req_word.order > req_word.degree) || (arg_mag > 33'h4000_0000)) begin
                  bad_in   = 1'b1;
                  p1_in    = 64'sd0;
                  state_in = S_FIN;
               end else begin
                  bad_in   = 1'b0;
                  issue_in = 1'b1;
                  state_in = S_XSQ;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in.bad_args = bad_ff;
               if (p1_ff[63]) begin
                  rsp_word_in.value = (rmag > 48'h8000_0000) ? 32'sh8000_0000
                                                             : 32'(-rmag);
               end else begin
                  rsp_word_in.value = (rmag > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                             : rmag[31:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            if (alu_rsp.done) begin
               issue_in = 1'b1;
               case (state_ff)
                  S_XSQ: begin
                     omx2_in = nal_pkg::ONE_Q60 - r;
                     prod_in = nal_pkg::ONE_Q60;
                     i_in    = 9'd1;
                     state_in = (m_ff == 8'd0) ? S_SQ1 : S_PM1;
                  end
                  S_PM1: begin
                     prod_in  = r;
                     state_in = S_PDIV;
                  end
                  S_PDIV: begin
                     t_in     = $signed(r);
                     state_in = S_PM2;
                  end
                  S_PM2: begin
                     prod_in = r;
                     if (i_ff[7:0] == m_ff) begin
                        state_in = S_SQ1;
                     end else begin
                        i_in     = ll_next;
                        state_in = S_PM1;
                     end
                  end
                  S_SQ1: begin
                     sa_in    = r;
                     state_in = S_CM;
                  end
                  S_CM: begin
                     t_in     = $signed(r);
                     state_in = S_SQ2;
                  end
                  S_SQ2: begin
                     sb_in    = r;
                     state_in = S_RT;
                  end
                  S_RT: begin
                     p0_in    = m_ff[0] ? -$signed(p0v) : $signed(p0v);
                     p1_in    = m_ff[0] ? -$signed(p0v) : $signed(p0v);
                     first_in = 1'b1;
                     if (l_ff == m_ff) begin
                        issue_in = 1'b0;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_RS1;
                     end
                  end
                  S_RS1: begin
                     sn_in    = r[31:0];
                     state_in = S_RS2;
                  end
                  S_RS2: begin
                     sd_in    = r[31:0];
                     state_in = S_RD1;
                  end
                  S_RD1: begin
                     f_in     = r;
                     state_in = S_RD2;
                  end
                  S_RD2: begin
                     inv_in = r;
                     if (first_ff) begin
                        invp_in  = r;
                        state_in = S_P1A;
                     end else begin
                        state_in = S_RA;
                     end
                  end
                  S_P1A: begin
                     t_in     = sres;
                     state_in = S_P1B;
                  end
                  S_P1B: begin
                     p1_in    = sres;
                     first_in = 1'b0;
                     i_in     = {1'b0, m_ff} + 9'd2;
                     if (({1'b0, m_ff} + 9'd2) > {1'b0, l_ff}) begin
                        issue_in = 1'b0;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_RS1;
                     end
                  end
                  S_RA: begin
                     t_in     = sres;
                     state_in = S_RB;
                  end
                  S_RB: begin
                     t_in     = t_ff - sres;
                     state_in = S_RC;
                  end
                  S_RC: begin
                     p1_in   = sres;
                     p0_in   = p1_ff;
                     invp_in = inv_ff;
                     i_in    = ll_next;
                     if (ll_next > {1'b0, l_ff}) begin
                        issue_in = 1'b0;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_RS1;
                     end
                  end
                  default: begin
                     issue_in = 1'b0;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bad_ff      <= bad_in;
      first_ff    <= first_in;
      l_ff        <= l_in;
      m_ff        <= m_in;
      x_ff        <= x_in;
      xm_ff       <= xm_in;
      omx2_ff     <= omx2_in;
      prod_ff     <= prod_in;
      i_ff        <= i_in;
      t_ff        <= t_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      sn_ff       <= sn_in;
      sd_ff       <= sd_in;
      f_ff        <= f_in;
      inv_ff      <= inv_in;
      invp_ff     <= invp_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> rtl/nal_checker.sv
module nal_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input nal_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input nal_pkg::rsp_word_type rsp_word
);

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // rejected arguments give zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.bad_args |-> rsp_word.value == 32'sd0)
      else $error("bad_args with nonzero value");

   // one word in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after acceptance");

   // nothing to deliver straight out of reset
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind normalized_assoc_legendre_top nal_checker u_nal_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
